// ----- hw/rtl/s5hp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s5hp_pkg
// Shared types, codes and helpers of the SOCKS5 server handshake parser.
// ----------------------------------------------------------------------------
package s5hp_pkg;

	localparam int MAX_CRED_LEN = 16;
	localparam int CRED_BYTES   = 16;
	localparam int MAX_RESULTS  = 3;

	// Configuration register indexes (byte address is 8 times the index).
	localparam logic [2:0] REG_USER_LENGTH     = 3'd0;
	localparam logic [2:0] REG_USER_BYTES_LOW  = 3'd1;
	localparam logic [2:0] REG_USER_BYTES_HIGH = 3'd2;
	localparam logic [2:0] REG_PASS_LENGTH     = 3'd3;
	localparam logic [2:0] REG_PASS_BYTES_LOW  = 3'd4;
	localparam logic [2:0] REG_PASS_BYTES_HIGH = 3'd5;

	// Protocol bytes.
	localparam logic [7:0] BYTE_SOCKS_VER = 8'h05;
	localparam logic [7:0] BYTE_METH_PASS = 8'h02;
	localparam logic [7:0] BYTE_METH_NONE = 8'hFF;
	localparam logic [7:0] BYTE_AUTH_VER  = 8'h01;
	localparam logic [7:0] BYTE_AUTH_OK   = 8'h00;
	localparam logic [7:0] BYTE_AUTH_BAD  = 8'h01;
	localparam logic [7:0] BYTE_CMD_CONN  = 8'h01;
	localparam logic [7:0] BYTE_RSV       = 8'h00;
	localparam logic [7:0] BYTE_ATYP_IPV4 = 8'h01;
	localparam logic [7:0] BYTE_ATYP_DOM  = 8'h03;
	localparam logic [7:0] BYTE_ATYP_IPV6 = 8'h04;
	localparam logic [7:0] IPV4_BYTES     = 8'd4;
	localparam logic [7:0] IPV6_BYTES     = 8'd16;

	typedef enum logic [1:0] {
		KIND_REPLY = 2'd0,
		KIND_ADDR  = 2'd1,
		KIND_PORT  = 2'd2,
		KIND_FAIL  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ADDR_IPV4   = 2'd0,
		ADDR_DOMAIN = 2'd1,
		ADDR_IPV6   = 2'd2,
		ADDR_UNUSED = 2'd3
	} addr_kind_t;

	typedef enum logic [3:0] {
		FAIL_NONE      = 4'd0,
		FAIL_GREET_VER = 4'd1,
		FAIL_NO_METHOD = 4'd2,
		FAIL_AUTH_VER  = 4'd3,
		FAIL_CREDS     = 4'd4,
		FAIL_REQ_VER   = 4'd5,
		FAIL_RESERVED  = 4'd6,
		FAIL_COMMAND   = 4'd7,
		FAIL_ADDR_TYPE = 4'd8
	} fail_t;

	typedef enum logic [18:0] {
		PH_IDLE  = 19'h00001,
		PH_GVER  = 19'h00002,
		PH_GCNT  = 19'h00004,
		PH_GMETH = 19'h00008,
		PH_AVER  = 19'h00010,
		PH_ULEN  = 19'h00020,
		PH_USER  = 19'h00040,
		PH_PLEN  = 19'h00080,
		PH_PASS  = 19'h00100,
		PH_RVER  = 19'h00200,
		PH_RCMD  = 19'h00400,
		PH_RRSV  = 19'h00800,
		PH_ATYP  = 19'h01000,
		PH_ADDR  = 19'h02000,
		PH_DLEN  = 19'h04000,
		PH_PHI   = 19'h08000,
		PH_PLO   = 19'h10000,
		PH_DONE  = 19'h20000,
		PH_FAIL  = 19'h40000
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		addr_kind_t ttype;
		logic [15:0] port;
		fail_t      fail;
	} result_t;

	function automatic result_t mk_result(kind_t kind, logic [7:0] data, addr_kind_t ttype,
			logic [15:0] port, fail_t fail);
		result_t r;
		r.kind  = kind;
		r.data  = data;
		r.ttype = ttype;
		r.port  = port;
		r.fail  = fail;
		return r;
	endfunction

	// A received length matches only if it equals the configured one, stays within the
	// length limit and fits the store.
	function automatic logic len_ok(logic [7:0] got, logic [4:0] want, logic [7:0] max_len);
		return (got == {3'b000, want}) && (got <= max_len) && (got <= 8'(CRED_BYTES));
	endfunction

	// Positions past the stored bytes never match.
	function automatic logic cred_hit(logic [63:0] lo, logic [63:0] hi, logic [7:0] idx,
			logic [7:0] b);
		logic [127:0] bytes;
		bytes = {hi, lo};
		if (idx < 8'(CRED_BYTES)) begin
			return bytes[{idx[3:0], 3'b000} +: 8] == b;
		end
		return 1'b0;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/socks5_handshake_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// socks5_handshake_parser
// Parses client bytes of one SOCKS5 connection: greeting, password
// sub-negotiation and CONNECT request, and emits replies, address, port and failures.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  client_byte in tdata, conn_start in tuser
// m_*       out        m_tvalid/m_tready  reply/address/port/failure, kind in tuser
// APB       in/out     psel/penable       credential registers, 64-bit data
//
// Each byte is decoded in the cycle it is accepted; its results sit in a
// result register and leave one per cycle while m_tready is high. A byte
// with two or three results holds the input until its last one leaves the
// single-item output port. arst_n clears the parser to idle and the
// credentials to zero. The input is taken again in the cycle the final
// result of the previous byte leaves.
module socks5_handshake_parser #(
	parameter int MAX_CRED_LEN_P = s5hp_pkg::MAX_CRED_LEN
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] client_byte
	input  wire logic [0:0]  s_tuser,   // [0] conn_start
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [7:0] out_byte, [9:8] target_type,
	                                    // [25:10] dest_port, [29:26] fail_code
	output logic [1:0]       m_tuser,   // [1:0] out_kind
	output logic             m_tlast,   // last
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);
	import s5hp_pkg::*;

	localparam logic [7:0] CRED_LIMIT = 8'(MAX_CRED_LEN_P);

	logic [4:0]  user_len_q;
	logic [63:0] user_lo_q;
	logic [63:0] user_hi_q;
	logic [4:0]  pass_len_q;
	logic [63:0] pass_lo_q;
	logic [63:0] pass_hi_q;

	phase_t      phase_q;
	logic [7:0]  rem_q;
	logic [7:0]  bidx_q;
	logic        offered_q;
	logic        match_q;
	addr_kind_t  akind_q;
	logic [7:0]  pupper_q;

	phase_t      ph;
	logic [7:0]  rem;
	logic [7:0]  bidx;
	logic        offered;
	logic        match;
	addr_kind_t  akind;
	logic [7:0]  pupper;
	logic [7:0]  b;
	logic        do_fail;
	fail_t       fail_code;
	logic        do_method;
	logic        do_auth;
	result_t     res_n [MAX_RESULTS];
	logic [1:0]  cnt_n;

	result_t     res_q [MAX_RESULTS];
	logic [1:0]  cnt_q;
	logic [1:0]  idx_q;
	result_t     cur;

	logic        cfg_wr;
	logic        in_acc;
	logic        out_acc;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_len_q <= '0;
			user_lo_q  <= '0;
			user_hi_q  <= '0;
			pass_len_q <= '0;
			pass_lo_q  <= '0;
			pass_hi_q  <= '0;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				REG_USER_LENGTH:     user_len_q <= pwdata[4:0];
				REG_USER_BYTES_LOW:  user_lo_q  <= pwdata;
				REG_USER_BYTES_HIGH: user_hi_q  <= pwdata;
				REG_PASS_LENGTH:     pass_len_q <= pwdata[4:0];
				REG_PASS_BYTES_LOW:  pass_lo_q  <= pwdata;
				REG_PASS_BYTES_HIGH: pass_hi_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			REG_USER_LENGTH:     prdata = {59'd0, user_len_q};
			REG_USER_BYTES_LOW:  prdata = user_lo_q;
			REG_USER_BYTES_HIGH: prdata = user_hi_q;
			REG_PASS_LENGTH:     prdata = {59'd0, pass_len_q};
			REG_PASS_BYTES_LOW:  prdata = pass_lo_q;
			REG_PASS_BYTES_HIGH: prdata = pass_hi_q;
			default:             prdata = '0;
		endcase
	end

	// Decode of one client byte.
	always_comb begin
		b         = s_tdata;
		ph        = phase_q;
		rem       = rem_q;
		bidx      = bidx_q;
		offered   = offered_q;
		match     = match_q;
		akind     = akind_q;
		pupper    = pupper_q;
		do_fail   = 1'b0;
		fail_code = FAIL_NONE;
		do_method = 1'b0;
		do_auth   = 1'b0;
		cnt_n     = 2'd0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res_n[i] = mk_result(KIND_REPLY, 8'h00, ADDR_IPV4, 16'h0000, FAIL_NONE);
		end

		if (s_tuser[0]) begin
			ph      = PH_GVER;
			rem     = '0;
			bidx    = '0;
			offered = 1'b0;
			match   = 1'b1;
			akind   = ADDR_IPV4;
			pupper  = '0;
		end

		case (ph)
			PH_GVER: begin
				if (b != BYTE_SOCKS_VER) begin
					do_fail = 1'b1; fail_code = FAIL_GREET_VER;
				end else begin
					ph = PH_GCNT;
				end
			end
			PH_GCNT: begin
				rem = b;
				if (b == 8'd0) do_method = 1'b1;
				else ph = PH_GMETH;
			end
			PH_GMETH: begin
				if (b == BYTE_METH_PASS) offered = 1'b1;
				rem = rem - 8'd1;
				if (rem == 8'd0) do_method = 1'b1;
			end
			PH_AVER: begin
				if (b != BYTE_AUTH_VER) begin
					do_fail = 1'b1; fail_code = FAIL_AUTH_VER;
				end else begin
					ph = PH_ULEN;
				end
			end
			PH_ULEN: begin
				match = len_ok(b, user_len_q, CRED_LIMIT);
				rem   = b;
				bidx  = '0;
				ph    = (b == 8'd0) ? PH_PLEN : PH_USER;
			end
			PH_USER: begin
				if (!cred_hit(user_lo_q, user_hi_q, bidx, b)) match = 1'b0;
				bidx = bidx + 8'd1;
				rem  = rem - 8'd1;
				if (rem == 8'd0) ph = PH_PLEN;
			end
			PH_PLEN: begin
				if (!len_ok(b, pass_len_q, CRED_LIMIT)) match = 1'b0;
				rem  = b;
				bidx = '0;
				if (b == 8'd0) do_auth = 1'b1;
				else ph = PH_PASS;
			end
			PH_PASS: begin
				if (!cred_hit(pass_lo_q, pass_hi_q, bidx, b)) match = 1'b0;
				bidx = bidx + 8'd1;
				rem  = rem - 8'd1;
				if (rem == 8'd0) do_auth = 1'b1;
			end
			PH_RVER: begin
				if (b != BYTE_SOCKS_VER) begin
					do_fail = 1'b1; fail_code = FAIL_REQ_VER;
				end else begin
					ph = PH_RCMD;
				end
			end
			PH_RCMD: begin
				if (b != BYTE_CMD_CONN) begin
					do_fail = 1'b1; fail_code = FAIL_COMMAND;
				end else begin
					ph = PH_RRSV;
				end
			end
			PH_RRSV: begin
				if (b != BYTE_RSV) begin
					do_fail = 1'b1; fail_code = FAIL_RESERVED;
				end else begin
					ph = PH_ATYP;
				end
			end
			PH_ATYP: begin
				if (b == BYTE_ATYP_IPV4) begin
					akind = ADDR_IPV4; rem = IPV4_BYTES; ph = PH_ADDR;
				end else if (b == BYTE_ATYP_IPV6) begin
					akind = ADDR_IPV6; rem = IPV6_BYTES; ph = PH_ADDR;
				end else if (b == BYTE_ATYP_DOM) begin
					akind = ADDR_DOMAIN; ph = PH_DLEN;
				end else begin
					do_fail = 1'b1; fail_code = FAIL_ADDR_TYPE;
				end
			end
			PH_DLEN: begin
				rem = b;
				ph  = (b == 8'd0) ? PH_PHI : PH_ADDR;
			end
			PH_ADDR: begin
				res_n[0] = mk_result(KIND_ADDR, b, akind, 16'h0000, FAIL_NONE);
				cnt_n    = 2'd1;
				rem      = rem - 8'd1;
				if (rem == 8'd0) ph = PH_PHI;
			end
			PH_PHI: begin
				pupper = b;
				ph     = PH_PLO;
			end
			PH_PLO: begin
				res_n[0] = mk_result(KIND_PORT, 8'h00, akind, {pupper, b}, FAIL_NONE);
				cnt_n    = 2'd1;
				ph       = PH_DONE;
			end
			default: ;
		endcase

		if (do_fail) begin
			res_n[0] = mk_result(KIND_FAIL, 8'h00, akind, 16'h0000, fail_code);
			cnt_n    = 2'd1;
			ph       = PH_FAIL;
		end

		if (do_method) begin
			res_n[0] = mk_result(KIND_REPLY, BYTE_SOCKS_VER, akind, 16'h0000, FAIL_NONE);
			if (offered) begin
				res_n[1] = mk_result(KIND_REPLY, BYTE_METH_PASS, akind, 16'h0000, FAIL_NONE);
				cnt_n    = 2'd2;
				ph       = PH_AVER;
			end else begin
				res_n[1] = mk_result(KIND_REPLY, BYTE_METH_NONE, akind, 16'h0000, FAIL_NONE);
				res_n[2] = mk_result(KIND_FAIL, 8'h00, akind, 16'h0000, FAIL_NO_METHOD);
				cnt_n    = 2'd3;
				ph       = PH_FAIL;
			end
		end

		if (do_auth) begin
			res_n[0] = mk_result(KIND_REPLY, BYTE_AUTH_VER, akind, 16'h0000, FAIL_NONE);
			if (match) begin
				res_n[1] = mk_result(KIND_REPLY, BYTE_AUTH_OK, akind, 16'h0000, FAIL_NONE);
				cnt_n    = 2'd2;
				ph       = PH_RVER;
			end else begin
				res_n[1] = mk_result(KIND_REPLY, BYTE_AUTH_BAD, akind, 16'h0000, FAIL_NONE);
				res_n[2] = mk_result(KIND_FAIL, 8'h00, akind, 16'h0000, FAIL_CREDS);
				cnt_n    = 2'd3;
				ph       = PH_FAIL;
			end
		end
	end

	// Result register: a bundle of up to three results and a read pointer.
	assign cur      = res_q[idx_q];
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tlast  = (idx_q == (cnt_q - 2'd1));
	assign m_tuser  = cur.kind;
	assign m_tdata  = {2'b00, cur.fail, cur.port, cur.ttype, cur.data};
	assign out_acc  = m_tvalid && m_tready;
	// A new byte enters once the last result of the previous one is leaving.
	assign s_tready = !m_tvalid || (m_tready && m_tlast);
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			rem_q     <= '0;
			bidx_q    <= '0;
			offered_q <= 1'b0;
			match_q   <= 1'b1;
			akind_q   <= ADDR_IPV4;
			pupper_q  <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
		end else begin
			if (in_acc) begin
				phase_q   <= ph;
				rem_q     <= rem;
				bidx_q    <= bidx;
				offered_q <= offered;
				match_q   <= match;
				akind_q   <= akind;
				pupper_q  <= pupper;
				cnt_q     <= cnt_n;
				idx_q     <= '0;
			end else if (out_acc) begin
				if (m_tlast) cnt_q <= '0;
				else idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				res_q[i] <= res_n[i];
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/s5hp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s5hp_checker
// Port-level checks of the SOCKS5 handshake parser, bound to its top level.
// ----------------------------------------------------------------------------
module s5hp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [7:0]  s_tdata,
	input wire logic [0:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);
	import s5hp_pkg::*;

	// A stalled result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// With no result pending the parser must take client bytes.
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty result register");

	// A failure is the final result of its byte and carries a reason but no byte and no port.
	a_fail_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_FAIL |-> m_tlast && m_tdata[7:0] == 8'h00
			&& m_tdata[25:10] == 16'h0000 && m_tdata[29:26] != FAIL_NONE)
		else $error("malformed failure result");

	// The port result is always the final result of its byte.
	a_port_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_PORT |-> m_tlast && m_tdata[7:0] == 8'h00
			&& m_tdata[29:26] == FAIL_NONE)
		else $error("malformed port result");

	// Reply and address bytes carry no port and no failure reason.
	a_byte_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_REPLY || m_tuser == KIND_ADDR)
			|-> m_tdata[25:10] == 16'h0000 && m_tdata[29:26] == FAIL_NONE)
		else $error("malformed byte result");

endmodule

bind socks5_handshake_parser s5hp_checker u_s5hp_checker (.*);
`default_nettype wire

// ----- tb/sv/socks5_handshake_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// socks5_handshake_checker
// Watches the client byte stream, the result stream and the register port of
// the SOCKS5 handshake parser. It predicts the results of every accepted byte
// and compares each accepted result, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module socks5_handshake_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] client_byte
	input  logic [0:0]  s_tuser,   // [0] conn_start
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [7:0] out_byte, [9:8] target_type,
	                               // [25:10] dest_port, [29:26] fail_code
	input  logic [1:0]  m_tuser,   // [1:0] out_kind
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          awaited_count,
	output int          results_checked
);
	import s5hp_pkg::*;

	typedef struct packed {
		result_t res;
		logic    last;
	} outcome_t;

	outcome_t awaited_results[$];
	outcome_t byte_results[$];

	// Parser state as the predictor sees it.
	phase_t     phase;
	logic [7:0] remaining;
	logic [7:0] byte_index;
	logic [7:0] port_upper;
	logic       password_offered;
	logic       creds_match;
	addr_kind_t address_kind;

	// Credentials as written over the register port.
	logic [4:0]   user_len_cfg;
	logic [4:0]   pass_len_cfg;
	logic [127:0] user_cfg;
	logic [127:0] pass_cfg;

	int fail_total;
	int checked_total;

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		fail_total++;
		$display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	task automatic emit(kind_t kind, logic [7:0] data, logic [15:0] port, fail_t code);
		outcome_t o;
		if (byte_results.size() < MAX_RESULTS) begin
			o.res.kind  = kind;
			o.res.data  = data;
			o.res.ttype = address_kind;
			o.res.port  = port;
			o.res.fail  = code;
			o.last      = 1'b0;
			byte_results.push_back(o);
		end
	endtask

	task automatic give_up(fail_t code);
		emit(KIND_FAIL, 8'h00, 16'h0000, code);
		phase = PH_FAIL;
	endtask

	// Byte idx of a stored credential; positions past the store never match a byte.
	function automatic logic [8:0] cred_at(logic [127:0] store, logic [7:0] idx);
		if (int'(idx) < CRED_BYTES) begin
			return {1'b0, store[8 * int'(idx) +: 8]};
		end
		return 9'h100;
	endfunction

	function automatic logic length_matches(logic [7:0] got, logic [4:0] want);
		return got == {3'b000, want} && int'(got) <= MAX_CRED_LEN && int'(got) <= CRED_BYTES;
	endfunction

	task automatic answer_methods();
		emit(KIND_REPLY, BYTE_SOCKS_VER, 16'h0000, FAIL_NONE);
		if (password_offered) begin
			emit(KIND_REPLY, BYTE_METH_PASS, 16'h0000, FAIL_NONE);
			phase = PH_AVER;
		end else begin
			emit(KIND_REPLY, BYTE_METH_NONE, 16'h0000, FAIL_NONE);
			give_up(FAIL_NO_METHOD);
		end
	endtask

	task automatic answer_auth();
		emit(KIND_REPLY, BYTE_AUTH_VER, 16'h0000, FAIL_NONE);
		if (creds_match) begin
			emit(KIND_REPLY, BYTE_AUTH_OK, 16'h0000, FAIL_NONE);
			phase = PH_RVER;
		end else begin
			emit(KIND_REPLY, BYTE_AUTH_BAD, 16'h0000, FAIL_NONE);
			give_up(FAIL_CREDS);
		end
	endtask

	task automatic parse_client_byte(logic [7:0] b, logic start);
		outcome_t o;
		byte_results.delete();
		if (start) begin
			phase            = PH_GVER;
			remaining        = 8'd0;
			byte_index       = 8'd0;
			password_offered = 1'b0;
			creds_match      = 1'b1;
			address_kind     = ADDR_IPV4;
			port_upper       = 8'd0;
		end
		case (phase)
			PH_GVER: begin
				if (b != BYTE_SOCKS_VER) give_up(FAIL_GREET_VER);
				else phase = PH_GCNT;
			end
			PH_GCNT: begin
				remaining = b;
				if (remaining == 8'd0) answer_methods();
				else phase = PH_GMETH;
			end
			PH_GMETH: begin
				if (b == BYTE_METH_PASS) password_offered = 1'b1;
				remaining = remaining - 8'd1;
				if (remaining == 8'd0) answer_methods();
			end
			PH_AVER: begin
				if (b != BYTE_AUTH_VER) give_up(FAIL_AUTH_VER);
				else phase = PH_ULEN;
			end
			PH_ULEN: begin
				creds_match = length_matches(b, user_len_cfg);
				remaining   = b;
				byte_index  = 8'd0;
				phase       = (b == 8'd0) ? PH_PLEN : PH_USER;
			end
			PH_USER: begin
				if (cred_at(user_cfg, byte_index) != {1'b0, b}) creds_match = 1'b0;
				byte_index = byte_index + 8'd1;
				remaining  = remaining - 8'd1;
				if (remaining == 8'd0) phase = PH_PLEN;
			end
			PH_PLEN: begin
				if (!length_matches(b, pass_len_cfg)) creds_match = 1'b0;
				remaining  = b;
				byte_index = 8'd0;
				if (remaining == 8'd0) answer_auth();
				else phase = PH_PASS;
			end
			PH_PASS: begin
				if (cred_at(pass_cfg, byte_index) != {1'b0, b}) creds_match = 1'b0;
				byte_index = byte_index + 8'd1;
				remaining  = remaining - 8'd1;
				if (remaining == 8'd0) answer_auth();
			end
			PH_RVER: begin
				if (b != BYTE_SOCKS_VER) give_up(FAIL_REQ_VER);
				else phase = PH_RCMD;
			end
			PH_RCMD: begin
				if (b != BYTE_CMD_CONN) give_up(FAIL_COMMAND);
				else phase = PH_RRSV;
			end
			PH_RRSV: begin
				if (b != BYTE_RSV) give_up(FAIL_RESERVED);
				else phase = PH_ATYP;
			end
			PH_ATYP: begin
				if (b == BYTE_ATYP_IPV4) begin
					address_kind = ADDR_IPV4;
					remaining    = IPV4_BYTES;
					phase        = PH_ADDR;
				end else if (b == BYTE_ATYP_IPV6) begin
					address_kind = ADDR_IPV6;
					remaining    = IPV6_BYTES;
					phase        = PH_ADDR;
				end else if (b == BYTE_ATYP_DOM) begin
					address_kind = ADDR_DOMAIN;
					phase        = PH_DLEN;
				end else begin
					give_up(FAIL_ADDR_TYPE);
				end
			end
			PH_DLEN: begin
				remaining = b;
				phase     = (b == 8'd0) ? PH_PHI : PH_ADDR;
			end
			PH_ADDR: begin
				emit(KIND_ADDR, b, 16'h0000, FAIL_NONE);
				remaining = remaining - 8'd1;
				if (remaining == 8'd0) phase = PH_PHI;
			end
			PH_PHI: begin
				port_upper = b;
				phase      = PH_PLO;
			end
			PH_PLO: begin
				emit(KIND_PORT, 8'h00, {port_upper, b}, FAIL_NONE);
				phase = PH_DONE;
			end
			default: ;
		endcase
		for (int i = 0; i < byte_results.size(); i++) begin
			o      = byte_results[i];
			o.last = (i == byte_results.size() - 1);
			awaited_results.push_back(o);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			phase            = PH_IDLE;
			remaining        = 8'd0;
			byte_index       = 8'd0;
			port_upper       = 8'd0;
			password_offered = 1'b0;
			creds_match      = 1'b1;
			address_kind     = ADDR_IPV4;
			user_len_cfg     = 5'd0;
			pass_len_cfg     = 5'd0;
			user_cfg         = '0;
			pass_cfg         = '0;
			fail_total       = 0;
			checked_total    = 0;
			awaited_results.delete();
			mismatches      <= 0;
			awaited_count   <= 0;
			results_checked <= 0;
		end else begin
			// A result leaving now belongs to an earlier byte, so it is matched first.
			if (m_tvalid && m_tready) begin
				checked_total++;
				if (awaited_results.size() == 0) begin
					report("result with nothing expected", {m_tdata[29:0], m_tuser}, 32'h0);
				end else begin
					want = awaited_results.pop_front();
					if (m_tuser != want.res.kind)
						report("out_kind", 32'(m_tuser), 32'(want.res.kind));
					if (m_tdata[7:0] != want.res.data)
						report("out_byte", 32'(m_tdata[7:0]), 32'(want.res.data));
					if (m_tdata[9:8] != want.res.ttype)
						report("target_type", 32'(m_tdata[9:8]), 32'(want.res.ttype));
					if (m_tdata[25:10] != want.res.port)
						report("dest_port", 32'(m_tdata[25:10]), 32'(want.res.port));
					if (m_tdata[29:26] != want.res.fail)
						report("fail_code", 32'(m_tdata[29:26]), 32'(want.res.fail));
					if (m_tlast != want.last)
						report("last", 32'(m_tlast), 32'(want.last));
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					REG_USER_LENGTH:     user_len_cfg = pwdata[4:0];
					REG_USER_BYTES_LOW:  user_cfg[63:0] = pwdata;
					REG_USER_BYTES_HIGH: user_cfg[127:64] = pwdata;
					REG_PASS_LENGTH:     pass_len_cfg = pwdata[4:0];
					REG_PASS_BYTES_LOW:  pass_cfg[63:0] = pwdata;
					REG_PASS_BYTES_HIGH: pass_cfg[127:64] = pwdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) parse_client_byte(s_tdata, s_tuser[0]);
			mismatches      <= fail_total;
			awaited_count   <= awaited_results.size();
			results_checked <= checked_total;
		end
	end

endmodule

// ----- tb/sv/socks5_handshake_parser_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// socks5_handshake_parser_test
// Drives SOCKS5 client sessions into the handshake parser: a few directed
// sessions under the reset credentials, then mostly well-formed random
// sessions with broken ones mixed in, over several credential settings.
// Source gaps and sink stalls vary by phase; the checker does the comparing.
// ----------------------------------------------------------------------------
module socks5_handshake_parser_test;
	import s5hp_pkg::*;

	localparam int IDLE_LIMIT    = 300;
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_BYTES  = 336;
	localparam int SETTINGS      = 6;

	// Address with no register behind it; writes there must change nothing.
	localparam logic [2:0] REG_UNMAPPED = 3'd6;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = 8'h00;   // [7:0] client_byte
	logic [0:0]  s_tuser  = 1'b0;    // [0] conn_start
	logic        s_tready;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;            // [7:0] out_byte, [9:8] target_type,
	                                 // [25:10] dest_port, [29:26] fail_code
	logic [1:0]  m_tuser;            // [1:0] out_kind
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [5:0]  paddr    = 6'd0;
	logic [63:0] pwdata   = 64'd0;
	logic [63:0] prdata;
	logic        pready;

	int mismatches;
	int awaited_count;
	int results_checked;
	int bytes_sent = 0;
	int byte_budget = 0;
	int settings_used = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int stall_left = 0;
	bit source_gaps = 1'b0;
	logic sink_stalls = 1'b0;

	// Credentials currently loaded, used to build sessions that can log in.
	logic [4:0]   user_len_set = 5'd0;
	logic [4:0]   pass_len_set = 5'd0;
	logic [127:0] user_set = '0;
	logic [127:0] pass_set = '0;

	logic [7:0] session_bytes[$];

	socks5_handshake_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	socks5_handshake_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.mismatches      (mismatches),
		.awaited_count   (awaited_count),
		.results_checked (results_checked)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// With stalls enabled the sink alternates ready and stalled runs of random length; else it stays ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (!sink_stalls) begin
			m_tready <= 1'b1;
		end else if (stall_left == 0) begin
			m_tready   <= ~m_tready;
			stall_left <= m_tready ? $urandom_range(0, 5) : $urandom_range(0, 8);
		end else begin
			stall_left <= stall_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				idle_cycles, awaited_count);
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic bit chance(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic logic [7:0] other_than(logic [7:0] v);
		logic [7:0] r;
		r = 8'($urandom);
		if (r == v) r = ~v;
		return r;
	endfunction

	// Pushes v, or now and then a wrong byte in its place; returns 1 when wrong.
	function automatic bit push_field(logic [7:0] v, int wrong_pct);
		if (chance(wrong_pct)) begin
			session_bytes.push_back(other_than(v));
			return 1'b1;
		end
		session_bytes.push_back(v);
		return 1'b0;
	endfunction

	// Pushes a length byte and the credential bytes; returns 1 when they cannot match.
	function automatic bit push_credential(logic [4:0] len, logic [127:0] store);
		int n;
		bit spoiled;
		logic [7:0] v;
		n = chance(85) ? int'(len) : int'($urandom_range(0, 20));
		spoiled = (n != int'(len)) || (n > CRED_BYTES);
		session_bytes.push_back(8'(n));
		for (int i = 0; i < n; i++) begin
			v = (i < CRED_BYTES) ? store[8 * i +: 8] : 8'($urandom);
			if (chance(5)) begin
				v = other_than(v);
				spoiled = 1'b1;
			end
			session_bytes.push_back(v);
		end
		return spoiled;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic load_credentials(logic [4:0] ulen, logic [127:0] user, logic [4:0] plen,
			logic [127:0] pass);
		write_reg(REG_USER_LENGTH, 64'(ulen));
		write_reg(REG_USER_BYTES_LOW, user[63:0]);
		write_reg(REG_USER_BYTES_HIGH, user[127:64]);
		write_reg(REG_PASS_LENGTH, 64'(plen));
		write_reg(REG_PASS_BYTES_LOW, pass[63:0]);
		write_reg(REG_PASS_BYTES_HIGH, pass[127:64]);
		user_len_set = ulen;
		user_set     = user;
		pass_len_set = plen;
		pass_set     = pass;
		settings_used++;
	endtask

	task automatic send_byte(logic [7:0] b, logic start);
		int gap;
		if (source_gaps && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 10);
		end
		if (burst_left > 0) burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= start;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// A session that runs past the byte budget is cut short there.
	task automatic send_session();
		foreach (session_bytes[i]) begin
			if (byte_budget == 0 || bytes_sent < byte_budget)
				send_byte(session_bytes[i], i == 0);
		end
	endtask

	// Waits until every predicted result has left, then lets the parser settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One connection: mostly well formed, sometimes broken, cut short or trailed by junk.
	task automatic play_session();
		int n;
		int k;
		int pick;
		bit stop;
		logic [7:0] v;
		session_bytes.delete();
		stop = push_field(BYTE_SOCKS_VER, 4);
		if (!stop) begin
			n = chance(6) ? 0 : (chance(10) ? $urandom_range(5, 20) : $urandom_range(1, 4));
			k = (n > 0 && chance(85)) ? $urandom_range(0, n - 1) : -1;
			session_bytes.push_back(8'(n));
			for (int i = 0; i < n; i++)
				session_bytes.push_back(i == k ? BYTE_METH_PASS : 8'($urandom));
			stop = (k < 0);
		end
		if (!stop) stop = push_field(BYTE_AUTH_VER, 4);
		if (!stop) begin
			stop = push_credential(user_len_set, user_set);
			stop = push_credential(pass_len_set, pass_set) || stop;
		end
		if (!stop) stop = push_field(BYTE_SOCKS_VER, 4);
		if (!stop) stop = push_field(BYTE_CMD_CONN, 4);
		if (!stop) stop = push_field(BYTE_RSV, 4);
		if (!stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				session_bytes.push_back(BYTE_ATYP_IPV4);
				n = IPV4_BYTES;
			end else if (pick < 60) begin
				session_bytes.push_back(BYTE_ATYP_DOM);
				n = chance(10) ? 0 : $urandom_range(1, 12);
				session_bytes.push_back(8'(n));
			end else if (pick < 92) begin
				session_bytes.push_back(BYTE_ATYP_IPV6);
				n = IPV6_BYTES;
			end else begin
				do v = 8'($urandom);
				while (v == BYTE_ATYP_IPV4 || v == BYTE_ATYP_DOM || v == BYTE_ATYP_IPV6);
				session_bytes.push_back(v);
				stop = 1'b1;
			end
		end
		if (!stop) begin
			repeat (n) session_bytes.push_back(8'($urandom));
			repeat (2) begin
				v = chance(8) ? 8'h00 : (chance(8) ? 8'hFF : 8'($urandom));
				session_bytes.push_back(v);
			end
		end
		if (chance(8)) begin
			k = $urandom_range(1, session_bytes.size());
			while (session_bytes.size() > k) void'(session_bytes.pop_back());
		end
		if (chance(10)) repeat ($urandom_range(1, 3)) session_bytes.push_back(8'($urandom));
		send_session();
	endtask

	initial begin
		logic [127:0] user;
		logic [127:0] pass;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sessions under the reset credentials (both empty).
		send_byte(8'h77, 1'b0);   // no connection started yet, dropped
		session_bytes = {8'h04};
		send_session();
		session_bytes = {BYTE_SOCKS_VER, 8'h00};
		send_session();
		session_bytes = {BYTE_SOCKS_VER, 8'h01, BYTE_METH_PASS, 8'h00};
		send_session();
		// A one-byte password against an empty configured password is refused.
		session_bytes = {BYTE_SOCKS_VER, 8'h01, BYTE_METH_PASS, BYTE_AUTH_VER, 8'h00, 8'h01, 8'hFF};
		send_session();
		// Empty credentials log in; empty domain, top port, then a byte that is ignored.
		session_bytes = {BYTE_SOCKS_VER, 8'h01, BYTE_METH_PASS, BYTE_AUTH_VER, 8'h00, 8'h00,
			BYTE_SOCKS_VER, BYTE_CMD_CONN, BYTE_RSV, BYTE_ATYP_DOM, 8'h00, 8'hFF, 8'hFF, 8'h5A};
		send_session();
		drain();

		for (int s = 0; s < SETTINGS; s++) begin
			user = {$urandom, $urandom, $urandom, $urandom};
			pass = {$urandom, $urandom, $urandom, $urandom};
			case (s)
				0: load_credentials(5'd16, user, 5'd16, pass);
				1: load_credentials(5'd0, user, 5'd0, pass);
				// A configured length above the store can never log in.
				2: load_credentials(5'd31, '1, 5'd16, '1);
				3: load_credentials(5'd1, user, 5'd1, pass);
				4: load_credentials(5'($urandom_range(0, 16)), user, 5'($urandom_range(0, 16)), pass);
				default: load_credentials(5'd16, '0, 5'd8, pass);
			endcase
			if (s == 0) write_reg(REG_UNMAPPED, '1);
			source_gaps = (s != 1) && (s != 4);
			burst_left  = 0;
			sink_stalls <= (s != 1) && (s != 3);
			byte_budget = bytes_sent + RANDOM_BYTES / SETTINGS;
			while (bytes_sent < byte_budget) play_session();
			drain();
		end

		$display("covered %0d client bytes and %0d results over %0d credential settings",
			bytes_sent, results_checked, settings_used);
		$display("sessions mixed good logins, bad credentials and broken headers");
		if (mismatches == 0 && awaited_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
